FILE: hdl/sha1_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 engine package
// Shared types and constants for the byte-stream SHA-1 engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

    typedef logic [31:0]      t_word;
    typedef logic [4:0][31:0] t_chain;

    // chaining value after reset, element 0 is H0
    localparam t_chain SHA1_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                  32'hefcdab89, 32'h67452301};

    localparam t_word K_R0 = 32'h5a827999;
    localparam t_word K_R1 = 32'h6ed9eba1;
    localparam t_word K_R2 = 32'h8f1bbcdc;
    localparam t_word K_R3 = 32'hca62c1d6;

    localparam logic [6:0] ROUND_B1  = 7'd20;
    localparam logic [6:0] ROUND_B2  = 7'd40;
    localparam logic [6:0] ROUND_B3  = 7'd60;
    localparam logic [6:0] ROUND_ADD = 7'd80;

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [7:0]  ZERO_BYTE = 8'h00;
    localparam logic [5:0]  LEN_POS   = 6'd56;
    localparam logic [5:0]  POS_LAST  = 6'd63;
    localparam logic [63:0] BYTE_BITS = 64'd8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_item;
    } t_item;

    // request from the message controller to the compression unit
    typedef struct packed {
        logic  push;   // shift a packed word into the schedule window
        logic  start;  // the pushed word completes a block: run 80 rounds
        logic  init;   // restore the chaining words to the IV
        t_word word;
    } t_cmp_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD80,
        ST_PADZ,
        ST_LEN,
        ST_COMP,
        ST_OUT
    } t_state;

endpackage

FILE: hdl/sha1_hash_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 hash engine, top level
// Byte-stream SHA-1 with an input queue, a message controller and a
// one-round-per-cycle compression unit.
// ----------------------------------------------------------------------------
// Each request carries at most one message byte; a request with i_last_item
// set ends the message and, after padding, yields one 160-bit digest on the
// output channel (o_digest_word0 is H0), after which the engine starts a new
// message. A four-entry queue takes requests one per cycle while the back end
// works, as long as it is not full. The back end takes the bytes one at a
// time; after each full 64-byte block it stops for the compression (80 rounds
// and the chaining add) and for handing the block back. Finishing a message
// means inserting the padding and length bytes (up to 72), entering the
// length field and loading the digest, plus one or two block compressions.
// The digest sits in an output register, so the engine keeps taking bytes of
// the next message while it waits there.
// ----------------------------------------------------------------------------
module sha1_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_last_item,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_digest_word0,
    output logic [31:0] o_digest_word1,
    output logic [31:0] o_digest_word2,
    output logic [31:0] o_digest_word3,
    output logic [31:0] o_digest_word4
);
    import sha1_pkg::*;

    t_item    q_item;
    logic     q_valid;
    logic     q_pop;
    t_cmp_req cmp_req;
    logic     cmp_busy;
    t_chain   chain;
    t_chain   digest;

    sha1_in_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_has_byte   (i_has_byte),
        .i_last_item  (i_last_item),
        .o_item       (q_item),
        .o_item_valid (q_valid),
        .i_pop        (q_pop)
    );

    sha1_msg_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (q_item),
        .i_item_valid (q_valid),
        .o_pop        (q_pop),
        .o_cmp_req    (cmp_req),
        .i_busy       (cmp_busy),
        .i_chain      (chain),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_digest     (digest)
    );

    sha1_compress u_compress (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cmp_req),
        .o_busy  (cmp_busy),
        .o_chain (chain)
    );

    assign o_digest_word0 = digest[0];
    assign o_digest_word1 = digest[1];
    assign o_digest_word2 = digest[2];
    assign o_digest_word3 = digest[3];
    assign o_digest_word4 = digest[4];

endmodule

FILE: hdl/sha1_in_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 input queue
// Accepts input requests, drops the ones that carry neither a byte nor the
// end of the message, and buffers the rest for the message controller.
// ----------------------------------------------------------------------------
module sha1_in_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_has_byte,
    input  logic           i_last_item,
    output sha1_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_pop
);
    import sha1_pkg::*;

    t_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr;
    logic [QUEUE_AW:0]    r_count;
    logic                 accept;
    logic                 keep;
    logic                 pop;

    assign o_ready      = (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign accept       = i_valid && o_ready;
    assign keep         = accept && (i_has_byte || i_last_item);
    assign o_item_valid = (r_count != '0);
    assign pop          = i_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (keep) begin
            r_mem[r_wr_ptr] <= '{data_byte: i_data_byte, has_byte: i_has_byte,
                                 last_item: i_last_item};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (keep) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({keep, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hdl/sha1_compress.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 compression unit
// Sixteen-word schedule window as a shift line, one round per cycle,
// and the five chaining words.
// ----------------------------------------------------------------------------
module sha1_compress (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha1_pkg::t_cmp_req i_req,
    output logic               o_busy,
    output sha1_pkg::t_chain   o_chain
);
    import sha1_pkg::*;

    t_word      r_win [16];
    t_chain     r_work;
    t_chain     r_h;
    logic [6:0] r_round;
    logic       r_busy;

    t_word a, b, c, d, e;
    t_word f, k, tmp, w_mix, w_new;
    logic  do_round;

    assign a = r_work[0];
    assign b = r_work[1];
    assign c = r_work[2];
    assign d = r_work[3];
    assign e = r_work[4];

    assign do_round = r_busy && (r_round != ROUND_ADD);

    always_comb begin
        if (r_round < ROUND_B1) begin
            f = (b & c) | (~b & d);
            k = K_R0;
        end else if (r_round < ROUND_B2) begin
            f = b ^ c ^ d;
            k = K_R1;
        end else if (r_round < ROUND_B3) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_R2;
        end else begin
            f = b ^ c ^ d;
            k = K_R3;
        end
        tmp   = {a[26:0], a[31:27]} + f + e + k + r_win[0];
        // W[t+16] from the window that starts at W[t]
        w_mix = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];
        w_new = {w_mix[30:0], w_mix[31]};
    end

    always_ff @(posedge i_clk) begin
        if (do_round) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= w_new;
            r_work    <= {d, c, {b[1:0], b[31:2]}, a, tmp};
        end else if (!r_busy && i_req.push) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= i_req.word;
            if (i_req.start) begin
                r_work <= r_h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= '0;
            r_h     <= SHA1_IV;
        end else if (r_busy) begin
            if (r_round == ROUND_ADD) begin
                for (int i = 0; i < 5; i++) begin
                    r_h[i] <= r_h[i] + r_work[i];
                end
                r_busy <= 1'b0;
            end else begin
                r_round <= r_round + 1'b1;
            end
        end else begin
            if (i_req.push && i_req.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end
            if (i_req.init) begin
                r_h <= SHA1_IV;
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_chain = r_h;

endmodule

FILE: hdl/sha1_msg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message controller
// Packs message bytes into words, counts the length, inserts padding and
// the length field, starts block compressions and holds the digest output.
// ----------------------------------------------------------------------------
module sha1_msg_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha1_pkg::t_item     i_item,
    input  logic                i_item_valid,
    output logic                o_pop,
    output sha1_pkg::t_cmp_req  o_cmp_req,
    input  logic                i_busy,
    input  sha1_pkg::t_chain    i_chain,
    output logic                o_valid,
    input  logic                i_ready,
    output sha1_pkg::t_chain    o_digest
);
    import sha1_pkg::*;

    t_state       r_state, n_state;
    t_state       r_after, n_after;
    logic [5:0]   r_pos, n_pos;
    logic [23:0]  r_acc, n_acc;
    logic [63:0]  r_bits, n_bits;
    logic         r_out_valid, n_out_valid;
    t_chain       r_digest;
    logic         load_out;
    logic         ins;
    logic [7:0]   ins_byte;
    logic         blk_end;
    logic [7:0]   len_byte;
    logic [5:0]   len_sh;

    assign blk_end  = (r_pos == POS_LAST);
    // length byte i of the field is bits [63-8i -: 8]
    assign len_sh   = {~r_pos[2:0], 3'b000};
    assign len_byte = 8'(r_bits >> len_sh);

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_bits      = r_bits;
        n_out_valid = r_out_valid && !i_ready;
        load_out    = 1'b0;
        o_pop       = 1'b0;
        o_cmp_req   = '0;
        ins         = 1'b0;
        ins_byte    = ZERO_BYTE;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop = 1'b1;
                    if (i_item.has_byte) begin
                        ins      = 1'b1;
                        ins_byte = i_item.data_byte;
                        n_bits   = r_bits + BYTE_BITS;
                    end
                    if (i_item.has_byte && blk_end) begin
                        n_state = ST_COMP;
                        n_after = i_item.last_item ? ST_PAD80 : ST_IDLE;
                    end else if (i_item.last_item) begin
                        n_state = ST_PAD80;
                    end
                end
            end
            ST_PAD80: begin
                ins      = 1'b1;
                ins_byte = PAD_BYTE;
                n_state  = blk_end ? ST_COMP : ST_PADZ;
                n_after  = ST_PADZ;
            end
            ST_PADZ: begin
                if (r_pos == LEN_POS) begin
                    n_state = ST_LEN;
                end else begin
                    ins      = 1'b1;
                    ins_byte = ZERO_BYTE;
                    if (blk_end) begin
                        n_state = ST_COMP;
                        n_after = ST_PADZ;
                    end
                end
            end
            ST_LEN: begin
                ins      = 1'b1;
                ins_byte = len_byte;
                if (blk_end) begin
                    n_state = ST_COMP;
                    n_after = ST_OUT;
                end
            end
            ST_COMP: begin
                if (!i_busy) begin
                    n_state = r_after;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_ready) begin
                    load_out       = 1'b1;
                    n_out_valid    = 1'b1;
                    o_cmp_req.init = 1'b1;
                    n_bits         = '0;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (ins) begin
            n_acc = {r_acc[15:0], ins_byte};
            n_pos = r_pos + 1'b1;
            if (r_pos[1:0] == 2'b11) begin
                o_cmp_req.push  = 1'b1;
                o_cmp_req.start = blk_end;
                o_cmp_req.word  = {r_acc, ins_byte};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_after     <= ST_IDLE;
            r_pos       <= '0;
            r_bits      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_pos       <= n_pos;
            r_bits      <= n_bits;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (load_out) begin
            r_digest <= i_chain;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_digest = r_digest;

endmodule
